### rtl/magnetometer_iron_calibration_defines.svh
// assertion macros for the magnetometer iron calibration block
`ifndef MAGNETOMETER_IRON_CALIBRATION_DEFINES_SVH
`define MAGNETOMETER_IRON_CALIBRATION_DEFINES_SVH

// same-cycle implication
`define MIC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mic check failed");

// next-cycle implication
`define MIC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mic check failed");

`endif

### rtl/mic_pkg.sv
`default_nettype none
package mic_pkg;

  localparam int AXES = 3;
  localparam int AXW = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] CAL_COUNT_RST = 16'd1500;
  localparam logic [15:0] GAIN_RST = 16'd6144;
  localparam logic [15:0] SCALE_ONE = 16'd16384;
  localparam logic [15:0] SCALE_MAX = 16'hFFFF;
  localparam logic signed [15:0] S16_MAX = 16'sh7FFF;
  localparam logic signed [15:0] S16_MIN = -16'sh8000;
  localparam logic signed [23:0] OUT_MAX = 24'sd524287;
  localparam logic signed [23:0] OUT_MIN = -24'sd524288;

  localparam logic [CFG_IDX_W-1:0] CFG_CAL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd1;

  localparam logic FUNC_START = 1'b1;

  localparam logic [1:0] ST_CORRECTED = 2'd0;
  localparam logic [1:0] ST_ABSORBED = 2'd1;
  localparam logic [1:0] ST_CAL_DONE = 2'd2;
  localparam logic [1:0] ST_CAL_START = 2'd3;

  typedef struct packed {
    logic              func;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
    logic signed [15:0] mag_z;
  } mic_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [19:0] out_x;
    logic signed [19:0] out_y;
    logic signed [19:0] out_z;
    logic [2:0]         flat_axes;
  } mic_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CAL,
    S_CHORD,
    S_DIV_INIT,
    S_DIV_STEP,
    S_COR_A,
    S_COR_B,
    S_COR_R,
    S_OUT
  } mic_state_t;

endpackage
`default_nettype wire

### rtl/magnetometer_iron_calibration.sv
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   in_word   (mic_pkg::mic_in_t)
// out      output     out_valid / out_stall out_word  (mic_pkg::mic_out_t)
// cfg      input      cfg_we                cfg_index, cfg_wdata
//
// one word at a time; a corrected sample passes S_COR_A, S_COR_B and S_COR_R for each axis
// (the first two on the shared multiplier), and for the word that closes a run the 16-step
// restoring divider runs at most once per axis for the scale (not for flat or saturated axes).
// reset is synchronous on rst_n low; it restores unity scale, zero bias and register defaults.
// the result waits in an output register, so a new word is taken while out_stall holds it.
`default_nettype none
module magnetometer_iron_calibration (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire mic_pkg::mic_in_t                  in_word,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output mic_pkg::mic_out_t                      out_word,
  input  wire logic                              cfg_we,
  input  wire logic [mic_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [15:0]                       cfg_wdata
);

  localparam logic signed [49:0] RND_HALF = 50'sd33554432;

  mic_pkg::mic_state_t state_r, state_nxt;
  mic_pkg::mic_in_t    in_r;
  mic_pkg::mic_out_t   out_word_r;
  logic                out_valid_r;

  logic [15:0]         cal_count_r;
  logic [15:0]         gain_r;
  logic signed [15:0]  max_r   [3];
  logic signed [15:0]  min_r   [3];
  logic signed [15:0]  bias_r  [3];
  logic [15:0]         scale_r [3];
  logic [15:0]         chord_r [3];
  logic                calibrating_r;
  logic [15:0]         taken_r;

  logic [mic_pkg::AXW-1:0] ax_r;
  logic [17:0]         sum_r;
  logic [33:0]         rem_r;
  logic [33:0]         dsh_r;
  logic [15:0]         q_r;
  logic [3:0]          cnt_r;
  logic signed [49:0]  prod_r;
  logic [1:0]          status_r;
  logic signed [19:0]  res_r [3];
  logic [2:0]          flat_r;

  logic                accept;
  logic                out_load;
  logic                last_ax;
  logic [15:0]         target;
  logic                run_done;
  logic signed [15:0]  samp;
  logic signed [16:0]  diff;
  logic signed [16:0]  sum_mm;
  logic signed [16:0]  span;
  logic [15:0]         chord_w;
  logic [17:0]         den;
  logic [18:0]         dv;
  logic [33:0]         num;
  logic                sat;
  logic                chord_zero;
  logic                ge;
  logic signed [32:0]  mul_a;
  logic signed [16:0]  mul_b;
  logic signed [49:0]  mul_p;
  logic signed [49:0]  rnd;
  logic signed [23:0]  qq;
  logic signed [19:0]  qsat;

  assign accept = in_valid && !in_stall;
  assign last_ax = (ax_r == mic_pkg::AXW'(mic_pkg::AXES - 1));
  assign target = (cal_count_r == 16'd0) ? 16'd1 : cal_count_r;
  assign run_done = (taken_r >= target);

  always_comb begin
    unique case (ax_r)
      2'd0:    samp = in_r.mag_x;
      2'd1:    samp = in_r.mag_y;
      default: samp = in_r.mag_z;
    endcase
  end

  assign diff = 17'(samp) - 17'(bias_r[ax_r]);
  assign sum_mm = 17'(max_r[ax_r]) + 17'(min_r[ax_r]);
  assign span = 17'(max_r[ax_r]) - 17'(min_r[ax_r]);
  assign chord_w = span[16] ? 16'd0 : span[15:0];

  // scale = round(sum * 16384 / (AXES * chord)) as floor((sum*32768 + den) / (2*den))
  assign den = 18'(chord_r[ax_r]) * 18'(mic_pkg::AXES);
  assign dv = {den, 1'b0};
  assign num = {1'b0, sum_r, 15'd0} + 34'(den);
  assign sat = ({1'b0, num} >= {dv, 16'd0});
  assign chord_zero = (chord_r[ax_r] == 16'd0);
  assign ge = (rem_r >= dsh_r);

  // shared multiplier: scale*gain, then that product times the offset-free sample
  always_comb begin
    unique case (state_r)
      mic_pkg::S_COR_A: begin
        mul_a = $signed({17'd0, scale_r[ax_r]});
        mul_b = $signed({1'b0, gain_r});
      end
      mic_pkg::S_COR_B: begin
        mul_a = $signed({1'b0, prod_r[31:0]});
        mul_b = diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  assign rnd = prod_r + RND_HALF;
  assign qq = rnd[49:26];

  always_comb begin
    priority if (qq > mic_pkg::OUT_MAX) begin
      qsat = 20'(mic_pkg::OUT_MAX);
    end else if (qq < mic_pkg::OUT_MIN) begin
      qsat = 20'(mic_pkg::OUT_MIN);
    end else begin
      qsat = qq[19:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mic_pkg::S_IDLE: begin
        if (accept) begin
          priority if (in_word.func == mic_pkg::FUNC_START) begin
            state_nxt = mic_pkg::S_OUT;
          end else if (calibrating_r) begin
            state_nxt = mic_pkg::S_CAL;
          end else begin
            state_nxt = mic_pkg::S_COR_A;
          end
        end
      end
      mic_pkg::S_CAL: begin
        if (last_ax) begin
          state_nxt = run_done ? mic_pkg::S_CHORD : mic_pkg::S_OUT;
        end
      end
      mic_pkg::S_CHORD: begin
        if (last_ax) begin
          state_nxt = mic_pkg::S_DIV_INIT;
        end
      end
      mic_pkg::S_DIV_INIT: begin
        priority if (!chord_zero && !sat) begin
          state_nxt = mic_pkg::S_DIV_STEP;
        end else if (last_ax) begin
          state_nxt = mic_pkg::S_OUT;
        end else begin
          state_nxt = mic_pkg::S_DIV_INIT;
        end
      end
      mic_pkg::S_DIV_STEP: begin
        if (cnt_r == 4'd0) begin
          state_nxt = last_ax ? mic_pkg::S_OUT : mic_pkg::S_DIV_INIT;
        end
      end
      mic_pkg::S_COR_A: state_nxt = mic_pkg::S_COR_B;
      mic_pkg::S_COR_B: state_nxt = mic_pkg::S_COR_R;
      mic_pkg::S_COR_R: state_nxt = last_ax ? mic_pkg::S_OUT : mic_pkg::S_COR_A;
      mic_pkg::S_OUT: begin
        if (out_load) begin
          state_nxt = mic_pkg::S_IDLE;
        end
      end
      default: state_nxt = mic_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall = (state_r != mic_pkg::S_IDLE);
    out_load = (state_r == mic_pkg::S_OUT) && (!out_valid_r || !out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mic_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_word_r.status <= status_r;
      out_word_r.out_x <= res_r[0];
      out_word_r.out_y <= res_r[1];
      out_word_r.out_z <= res_r[2];
      out_word_r.flat_axes <= flat_r;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_count_r <= mic_pkg::CAL_COUNT_RST;
      gain_r <= mic_pkg::GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mic_pkg::CFG_CAL_COUNT: cal_count_r <= cfg_wdata;
        mic_pkg::CFG_GAIN:      gain_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // calibration state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        max_r[i] <= mic_pkg::S16_MIN;
        min_r[i] <= mic_pkg::S16_MAX;
        bias_r[i] <= '0;
        scale_r[i] <= mic_pkg::SCALE_ONE;
      end
      calibrating_r <= 1'b0;
      taken_r <= '0;
    end else begin
      unique case (state_r)
        mic_pkg::S_IDLE: begin
          if (accept) begin
            if (in_word.func == mic_pkg::FUNC_START) begin
              for (int i = 0; i < 3; i++) begin
                max_r[i] <= mic_pkg::S16_MIN;
                min_r[i] <= mic_pkg::S16_MAX;
              end
              taken_r <= '0;
              calibrating_r <= 1'b1;
            end else if (calibrating_r) begin
              taken_r <= taken_r + 16'd1;
            end
          end
        end
        mic_pkg::S_CAL: begin
          if (samp > max_r[ax_r]) begin
            max_r[ax_r] <= samp;
          end
          if (samp < min_r[ax_r]) begin
            min_r[ax_r] <= samp;
          end
          if (last_ax && run_done) begin
            calibrating_r <= 1'b0;
          end
        end
        mic_pkg::S_CHORD: begin
          bias_r[ax_r] <= sum_mm[16:1];
        end
        mic_pkg::S_DIV_INIT: begin
          priority if (chord_zero) begin
            scale_r[ax_r] <= mic_pkg::SCALE_ONE;
          end else if (sat) begin
            scale_r[ax_r] <= mic_pkg::SCALE_MAX;
          end else begin
            scale_r[ax_r] <= scale_r[ax_r];
          end
        end
        mic_pkg::S_DIV_STEP: begin
          if (cnt_r == 4'd0) begin
            scale_r[ax_r] <= {q_r[14:0], ge};
          end
        end
        default: ;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      mic_pkg::S_IDLE: begin
        if (accept) begin
          in_r <= in_word;
          ax_r <= '0;
          flat_r <= '0;
          for (int i = 0; i < 3; i++) begin
            res_r[i] <= '0;
          end
          priority if (in_word.func == mic_pkg::FUNC_START) begin
            status_r <= mic_pkg::ST_CAL_START;
          end else if (calibrating_r) begin
            status_r <= mic_pkg::ST_ABSORBED;
          end else begin
            status_r <= mic_pkg::ST_CORRECTED;
          end
        end
      end
      mic_pkg::S_CAL: begin
        if (last_ax) begin
          ax_r <= '0;
          sum_r <= '0;
          status_r <= run_done ? mic_pkg::ST_CAL_DONE : mic_pkg::ST_ABSORBED;
        end else begin
          ax_r <= ax_r + 2'd1;
        end
      end
      mic_pkg::S_CHORD: begin
        chord_r[ax_r] <= chord_w;
        sum_r <= sum_r + 18'(chord_w);
        ax_r <= last_ax ? '0 : ax_r + 2'd1;
      end
      mic_pkg::S_DIV_INIT: begin
        if (chord_zero) begin
          flat_r[ax_r] <= 1'b1;
        end
        if (!chord_zero && !sat) begin
          rem_r <= num;
          dsh_r <= {dv, 15'd0};
          cnt_r <= 4'd15;
          q_r <= '0;
        end else if (!last_ax) begin
          ax_r <= ax_r + 2'd1;
        end
      end
      mic_pkg::S_DIV_STEP: begin
        if (ge) begin
          rem_r <= rem_r - dsh_r;
        end
        q_r <= {q_r[14:0], ge};
        dsh_r <= {1'b0, dsh_r[33:1]};
        cnt_r <= cnt_r - 4'd1;
        if (cnt_r == 4'd0 && !last_ax) begin
          ax_r <= ax_r + 2'd1;
        end
      end
      mic_pkg::S_COR_A: prod_r <= mul_p;
      mic_pkg::S_COR_B: prod_r <= mul_p;
      mic_pkg::S_COR_R: begin
        res_r[ax_r] <= qsat;
        if (!last_ax) begin
          ax_r <= ax_r + 2'd1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_word = out_word_r;

endmodule
`default_nettype wire

### rtl/mic_checker.sv
`default_nettype none
`include "magnetometer_iron_calibration_defines.svh"
module mic_checker (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire mic_pkg::mic_out_t out_word
);

  logic non_sample;
  logic xyz_zero;
  logic flat_any;

  assign non_sample = out_valid && (out_word.status != mic_pkg::ST_CORRECTED);
  assign xyz_zero = (out_word.out_x == 20'sd0) && (out_word.out_y == 20'sd0) &&
                    (out_word.out_z == 20'sd0);
  assign flat_any = (out_word.flat_axes != 3'd0);

  `MIC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word))

  `MIC_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  `MIC_ASSERT_NOW(a_zero_fields, non_sample, xyz_zero)

  `MIC_ASSERT_NOW(a_flat_only_done, out_valid && flat_any, out_word.status == mic_pkg::ST_CAL_DONE)

endmodule

bind magnetometer_iron_calibration mic_checker u_mic_checker (.*);
`default_nettype wire

### tb/sv/tb.sv
`default_nettype none
module tb;
  import mic_pkg::*;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam int QUIET_LIMIT = 5000;
  localparam int RANDOM_WORDS = 1500;
  localparam int SETTLE_CYCLES = 60;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  mic_in_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  mic_out_t out_word;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int send_idle_pct = 23;
  int recv_stall_pct = 87;
  int errors = 0;
  int words_sent = 0;
  int quiet_cycles = 0;
  mic_out_t corrected_q[$];

  // predicted register and calibration state
  int cal_reg;
  int gain_reg;
  int axis_hi[AXES];
  int axis_lo[AXES];
  int bias_val[AXES];
  int scale_val[AXES];
  bit in_cal;
  int taken;

  magnetometer_iron_calibration uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  function automatic void reset_model();
    cal_reg = CAL_COUNT_RST;
    gain_reg = GAIN_RST;
    for (int i = 0; i < AXES; i++) begin
      axis_hi[i] = S16_MIN;
      axis_lo[i] = S16_MAX;
      bias_val[i] = 0;
      scale_val[i] = SCALE_ONE;
    end
    in_cal = 1'b0;
    taken = 0;
  endfunction

  function automatic logic [2:0] close_run();
    longint chord[AXES];
    longint total;
    longint den;
    longint q;
    int s;
    logic [2:0] flat;
    total = 0;
    flat = '0;
    for (int i = 0; i < AXES; i++) begin
      s = axis_hi[i] + axis_lo[i];
      bias_val[i] = s >>> 1;
      chord[i] = (axis_hi[i] > axis_lo[i]) ? longint'(axis_hi[i] - axis_lo[i]) : 0;
      total += chord[i];
    end
    for (int i = 0; i < AXES; i++) begin
      if (chord[i] == 0) begin
        scale_val[i] = SCALE_ONE;
        flat[i] = 1'b1;
      end else begin
        den = AXES * chord[i];
        q = (total * 2 * longint'(SCALE_ONE) + den) / (2 * den);
        scale_val[i] = (q > 65535) ? 65535 : int'(q);
      end
    end
    return flat;
  endfunction

  function automatic logic signed [19:0] correct_axis(logic signed [15:0] smp, int ax);
    longint p;
    longint q;
    p = (longint'(smp) - longint'(bias_val[ax])) * longint'(scale_val[ax])
        * longint'(gain_reg);
    q = (p + (longint'(1) << 25)) >>> 26;
    if (q > OUT_MAX) q = OUT_MAX;
    if (q < OUT_MIN) q = OUT_MIN;
    return q[19:0];
  endfunction

  function automatic mic_out_t predict_word(mic_in_t w);
    mic_out_t r;
    logic signed [15:0] m[AXES];
    r = '0;
    m[0] = w.mag_x;
    m[1] = w.mag_y;
    m[2] = w.mag_z;
    if (w.func == FUNC_START) begin
      for (int i = 0; i < AXES; i++) begin
        axis_hi[i] = S16_MIN;
        axis_lo[i] = S16_MAX;
      end
      taken = 0;
      in_cal = 1'b1;
      r.status = ST_CAL_START;
    end else if (in_cal) begin
      for (int i = 0; i < AXES; i++) begin
        if (m[i] > axis_hi[i]) axis_hi[i] = m[i];
        if (m[i] < axis_lo[i]) axis_lo[i] = m[i];
      end
      taken = (taken + 1) & 16'hFFFF;
      if (taken >= ((cal_reg == 0) ? 1 : cal_reg)) begin
        r.flat_axes = close_run();
        in_cal = 1'b0;
        r.status = ST_CAL_DONE;
      end else begin
        r.status = ST_ABSORBED;
      end
    end else begin
      r.out_x = correct_axis(m[0], 0);
      r.out_y = correct_axis(m[1], 1);
      r.out_z = correct_axis(m[2], 2);
      r.status = ST_CORRECTED;
    end
    return r;
  endfunction

  task automatic report_field(input string field, input int exp_v, input int act_v);
    errors++;
    $display("%0t %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
  endtask

  task automatic check_word(input mic_out_t exp_w, input mic_out_t act_w);
    if (exp_w.status !== act_w.status) report_field("status", exp_w.status, act_w.status);
    if (exp_w.out_x !== act_w.out_x) report_field("out_x", exp_w.out_x, act_w.out_x);
    if (exp_w.out_y !== act_w.out_y) report_field("out_y", exp_w.out_y, act_w.out_y);
    if (exp_w.out_z !== act_w.out_z) report_field("out_z", exp_w.out_z, act_w.out_z);
    if (exp_w.flat_axes !== act_w.flat_axes)
      report_field("flat_axes", exp_w.flat_axes, act_w.flat_axes);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (corrected_q.size() == 0) begin
        errors++;
        $display("%0t unexpected word: expected none, actual %p", $time, out_word);
      end else begin
        check_word(corrected_q.pop_front(), out_word);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_word(input logic func, input int x, input int y, input int z);
    mic_in_t w;
    w.func = func;
    w.mag_x = x[15:0];
    w.mag_y = y[15:0];
    w.mag_z = z[15:0];
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    corrected_q.push_back(predict_word(w));
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (corrected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // cal_count, gain, then one unused index that must be ignored
  task automatic write_regs(input logic [15:0] count, input logic [15:0] mg_gain);
    cfg_we <= 1'b1;
    cfg_index <= CFG_CAL_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_index <= CFG_GAIN;
    cfg_wdata <= mg_gain;
    @(posedge clk);
    cfg_index <= ($urandom_range(0, 1) != 0) ? CFG_SPARE_A : CFG_SPARE_B;
    cfg_wdata <= 16'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cal_reg = count;
    gain_reg = mg_gain;
  endtask

  function automatic int near(int center, int radius);
    int v;
    v = center + int'($urandom_range(0, 2 * radius)) - radius;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  task automatic test_reset_defaults();
    send_word(FUNC_SAMPLE, 32767, -32768, 0);
    send_word(FUNC_SAMPLE, -32768, 32767, 1);
    send_word(FUNC_SAMPLE, 12345, -1, -12345);
  endtask

  task automatic test_single_sample_run();
    wait_idle();
    write_regs(16'd0, 16'hFFFF);
    send_word(FUNC_START, $urandom, $urandom, $urandom);
    send_word(FUNC_SAMPLE, 32767, -32768, 5);
    send_word(FUNC_SAMPLE, -32768, 32767, -32768);
    send_word(FUNC_SAMPLE, 32767, -32768, 5);
  endtask

  task automatic test_full_chord_run();
    wait_idle();
    write_regs(16'd2, 16'hFFFF);
    send_word(FUNC_START, 0, 0, 0);
    send_word(FUNC_SAMPLE, 32767, -32768, 0);
    send_word(FUNC_SAMPLE, -32768, 32767, 1);
    send_word(FUNC_SAMPLE, 32767, 32767, 32767);
    send_word(FUNC_SAMPLE, -32768, -32768, -32768);
    wait_idle();
    write_regs(16'd2, 16'd0);
    send_word(FUNC_SAMPLE, 32767, -32768, 100);
  endtask

  task automatic test_restart_mid_run();
    wait_idle();
    write_regs(16'hFFFF, GAIN_RST);
    send_word(FUNC_START, 0, 0, 0);
    for (int k = 0; k < 3; k++) send_word(FUNC_SAMPLE, $urandom, $urandom, $urandom);
    send_word(FUNC_START, -1, -1, -1);
    for (int k = 0; k < 4; k++) send_word(FUNC_SAMPLE, $urandom, $urandom, $urandom);
    // lower the target below the samples already taken
    wait_idle();
    write_regs(16'd3, 16'd4096);
    send_word(FUNC_SAMPLE, 100, -200, 300);
    send_word(FUNC_SAMPLE, $urandom, $urandom, $urandom);
  endtask

  task automatic cal_run_segment();
    int count;
    int center[AXES];
    int radius[AXES];
    int restart_at;
    int k;
    int n;
    count = (cal_reg == 0) ? 1 : cal_reg;
    for (int i = 0; i < AXES; i++) begin
      center[i] = int'($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 5))
        0: radius[i] = 0;
        1: radius[i] = $urandom_range(1, 3);
        2: radius[i] = $urandom_range(0, 300);
        3: radius[i] = $urandom_range(0, 4000);
        default: radius[i] = $urandom_range(0, 65535);
      endcase
    end
    restart_at = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, count - 1)) : -1;
    send_word(FUNC_START, $urandom, $urandom, $urandom);
    k = 0;
    while (k < count) begin
      if (k == restart_at) begin
        send_word(FUNC_START, $urandom, $urandom, $urandom);
        restart_at = -1;
        k = 0;
      end
      send_word(FUNC_SAMPLE, near(center[0], radius[0]), near(center[1], radius[1]),
                near(center[2], radius[2]));
      k++;
    end
    n = $urandom_range(0, 8);
    for (int j = 0; j < n; j++) begin
      if ($urandom_range(0, 1) != 0)
        send_word(FUNC_SAMPLE, $urandom, $urandom, $urandom);
      else
        send_word(FUNC_SAMPLE, near(center[0], radius[0] + 100),
                  near(center[1], radius[1] + 100), near(center[2], radius[2] + 100));
    end
  endtask

  task automatic noise_segment();
    int n;
    n = $urandom_range(1, 12);
    for (int j = 0; j < n; j++)
      send_word(($urandom_range(0, 9) == 0) ? FUNC_START : FUNC_SAMPLE,
                $urandom, $urandom, $urandom);
  endtask

  task automatic run_random_phase(input int send_pct, input int stall_pct, input int words);
    int stop_at;
    logic [15:0] count;
    logic [15:0] mg;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    stop_at = words_sent + words;
    while (words_sent < stop_at) begin
      wait_idle();
      case ($urandom_range(0, 19))
        0: count = 16'd0;
        1: count = 16'hFFFF;
        2: count = 16'($urandom);
        default: count = 16'($urandom_range(1, 24));
      endcase
      case ($urandom_range(0, 9))
        0: mg = 16'd0;
        1: mg = 16'hFFFF;
        default: mg = 16'($urandom);
      endcase
      write_regs(count, mg);
      if (count <= 64 && $urandom_range(0, 4) != 0) cal_run_segment();
      else noise_segment();
    end
  endtask

  initial begin
    reset_model();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_single_sample_run();
    test_full_chord_run();
    test_restart_mid_run();
    run_random_phase(23, 87, RANDOM_WORDS / 3);
    run_random_phase(87, 23, RANDOM_WORDS / 3);
    run_random_phase(0, 0, RANDOM_WORDS / 3);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/mic_pkg.sv
rtl/magnetometer_iron_calibration.sv
rtl/mic_checker.sv
tb/sv/tb.sv
